>>> rtl/rmsq_pkg.sv
package rmsq_pkg;

  localparam int ID_W       = 16;
  localparam int FEET_W     = 5;
  localparam int INCH_IN_W  = 5;
  localparam int INCH_W     = 9;
  localparam int LIM_W      = 11;
  localparam int LIM100_W   = 18;
  localparam int CENTI_W    = 17;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CENTI_W - ID_W;

  localparam int IN_ID_LSB   = 0;
  localparam int IN_FEET_LSB = IN_ID_LSB + ID_W;
  localparam int IN_INCH_LSB = IN_FEET_LSB + FEET_W;
  localparam int IN_LIM_LSB  = IN_INCH_LSB + INCH_IN_W;

  localparam int INCH_PER_FOOT = 12;
  localparam int CENTI_PER_IN  = 254;
  localparam int CENTI_PER_CM  = 100;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [INCH_W-1:0] inches;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic y_first;
    logic x_fits;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRUN,
    ST_CAPA,
    ST_CAPB,
    ST_MRG,
    ST_QSTART,
    ST_QCHK,
    ST_NONE
  } state_t;

endpackage

>>> rtl/rmsq_ram.sv
module rmsq_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rmsq_cmp.sv
module rmsq_cmp
  import rmsq_pkg::*;
(
  input  rec_t                x,
  input  rec_t                y,
  input  logic [LIM100_W-1:0] lim,
  output cmp_res_t            res,
  output logic [CENTI_W-1:0]  x_centi
);

  assign x_centi = CENTI_W'(x.inches) * CENTI_W'(CENTI_PER_IN);

  always_comb begin
    res.x_fits  = LIM100_W'(x_centi) <= lim;
    res.y_first = (y.inches < x.inches) || ((y.inches == x.inches) && (y.id > x.id));
  end

endmodule

>>> rtl/record_merge_sort_threshold_query_unit.sv
// channel | dir | tdata (low bit up)                         | tuser      | tlast
// s_      | in  | rec_id[15:0] feet[20:16] inches[25:21]     | func       | -
//         |     | limit_cm[36:26] zero[39:37]                |            |
// m_      | out | out_id[15:0] height_centi_cm[32:16]        | none_found | last
//         |     | zero[39:33]                                |            |
// A load is accepted while s_tready stays high.
// A query after new loads first merge-sorts the store through one compare unit,
// taking ceil(log2 n) passes.
// The scan then starts from the top of the sorted store, skips records above the limit and emits each one within it.
// m_tready low holds the scan; s_tready stays low until the last result is loaded.
// Reset clears control state only; the record memories are not cleared.
module record_merge_sort_threshold_query_unit
  import rmsq_pkg::*;
#(
  parameter int MAX_RECORDS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // rec_id, feet, inches, limit_cm, zero pad
  input  logic                   s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_id, height_centi_cm, zero pad
  output logic                   m_tuser,   // none_found
  output logic                   m_tlast
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int SW = CW + 2;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic sorted, sorted_next;
  logic cur, cur_next;
  logic [SW-1:0] lo, lo_next, w, w_next, mid, mid_next, hi, hi_next;
  logic [SW-1:0] i, i_next, j, j_next, k, k_next;
  logic init, init_next;
  rec_t a_rec, a_next, b_rec, b_next;
  logic [LIM100_W-1:0] lim, lim_next;
  logic [AW-1:0] idx, idx_next;

  logic out_load;
  logic [ID_W-1:0] out_id, out_id_next;
  logic [CENTI_W-1:0] out_centi, out_centi_next;
  logic out_none, out_none_next, out_last, out_last_next;

  logic ram_we, wsel;
  logic [AW-1:0] ram_waddr, rd_addr;
  rec_t ram_wdata, rd_rec;
  logic [REC_W-1:0] rdata0, rdata1;

  rec_t cmp_x;
  cmp_res_t cmp_res;
  logic [CENTI_W-1:0] x_centi;

  logic [SW-1:0] n_ext, lo_w, lo_2w, w2, i_inc, j_inc, k_inc;
  logic [SW-1:0] mid_calc, hi_calc;
  logic take_b, out_free;
  logic [INCH_W-1:0] load_total;

  rmsq_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram0 (
    .clk   (clk),
    .we    (ram_we && !wsel),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  rmsq_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram1 (
    .clk   (clk),
    .we    (ram_we && wsel),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  assign rd_rec = cur ? rec_t'(rdata1) : rec_t'(rdata0);
  assign cmp_x  = (state == ST_QCHK) ? rd_rec : a_rec;

  rmsq_cmp u_cmp (
    .x       (cmp_x),
    .y       (b_rec),
    .lim     (lim),
    .res     (cmp_res),
    .x_centi (x_centi)
  );

  assign n_ext    = SW'(count);
  assign w2       = w << 1;
  assign lo_w     = lo + w;
  assign lo_2w    = lo + w2;
  assign mid_calc = (lo_w > n_ext) ? n_ext : lo_w;
  assign hi_calc  = (lo_2w > n_ext) ? n_ext : lo_2w;
  assign i_inc    = i + SW'(1);
  assign j_inc    = j + SW'(1);
  assign k_inc    = k + SW'(1);
  assign take_b   = (j < hi) && ((i >= mid) || cmp_res.y_first);
  assign out_free = !m_tvalid || m_tready;
  assign load_total = INCH_W'(s_tdata[IN_FEET_LSB +: FEET_W]) * INCH_W'(INCH_PER_FOOT)
                    + INCH_W'(s_tdata[IN_INCH_LSB +: INCH_IN_W]);

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_centi, out_id};
  assign m_tuser  = out_none;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      sorted   <= 1'b1;
      cur      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      sorted   <= sorted_next;
      cur      <= cur_next;
      m_tvalid <= out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    w         <= w_next;
    mid       <= mid_next;
    hi        <= hi_next;
    i         <= i_next;
    j         <= j_next;
    k         <= k_next;
    init      <= init_next;
    a_rec     <= a_next;
    b_rec     <= b_next;
    lim       <= lim_next;
    idx       <= idx_next;
    out_id    <= out_id_next;
    out_centi <= out_centi_next;
    out_none  <= out_none_next;
    out_last  <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    sorted_next    = sorted;
    cur_next       = cur;
    lo_next        = lo;
    w_next         = w;
    mid_next       = mid;
    hi_next        = hi;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    init_next      = init;
    a_next         = a_rec;
    b_next         = b_rec;
    lim_next       = lim;
    idx_next       = idx;
    out_load       = 1'b0;
    out_id_next    = out_id;
    out_centi_next = out_centi;
    out_none_next  = out_none;
    out_last_next  = out_last;
    ram_we         = 1'b0;
    wsel           = cur;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = '{id: s_tdata[IN_ID_LSB +: ID_W], inches: load_total};
    rd_addr        = idx;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == FUNC_LOAD) begin
            if (count < CW'(MAX_RECORDS)) begin
              ram_we      = 1'b1;
              count_next  = count + CW'(1);
              sorted_next = 1'b0;
            end
          end else begin
            lim_next = LIM100_W'(s_tdata[IN_LIM_LSB +: LIM_W]) * LIM100_W'(CENTI_PER_CM);
            if (!sorted && (count > CW'(1))) begin
              w_next     = SW'(1);
              lo_next    = '0;
              state_next = ST_SRUN;
            end else begin
              sorted_next = 1'b1;
              state_next  = ST_QSTART;
            end
          end
        end
      end
      ST_SRUN: begin
        mid_next   = mid_calc;
        hi_next    = hi_calc;
        i_next     = lo;
        j_next     = mid_calc;
        k_next     = lo;
        rd_addr    = lo[AW-1:0];
        init_next  = 1'b1;
        state_next = ST_CAPA;
      end
      ST_CAPA: begin
        a_next = rd_rec;
        if (init) begin
          rd_addr    = j[AW-1:0];
          init_next  = 1'b0;
          state_next = ST_CAPB;
        end else begin
          state_next = ST_MRG;
        end
      end
      ST_CAPB: begin
        b_next     = rd_rec;
        state_next = ST_MRG;
      end
      ST_MRG: begin
        ram_we    = 1'b1;
        wsel      = ~cur;
        ram_waddr = k[AW-1:0];
        ram_wdata = take_b ? b_rec : a_rec;
        k_next    = k_inc;
        if (k_inc == hi) begin
          if (lo_2w >= n_ext) begin
            cur_next = ~cur;
            w_next   = w2;
            lo_next  = '0;
            if (w2 >= n_ext) begin
              sorted_next = 1'b1;
              state_next  = ST_QSTART;
            end else begin
              state_next = ST_SRUN;
            end
          end else begin
            lo_next    = lo_2w;
            state_next = ST_SRUN;
          end
        end else if (take_b) begin
          j_next     = j_inc;
          rd_addr    = j_inc[AW-1:0];
          state_next = ST_CAPB;
        end else begin
          i_next     = i_inc;
          rd_addr    = i_inc[AW-1:0];
          state_next = ST_CAPA;
        end
      end
      ST_QSTART: begin
        if (count == '0) begin
          state_next = ST_NONE;
        end else begin
          idx_next   = AW'(count - CW'(1));
          rd_addr    = AW'(count - CW'(1));
          state_next = ST_QCHK;
        end
      end
      ST_QCHK: begin
        if (cmp_res.x_fits) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_id_next    = rd_rec.id;
            out_centi_next = x_centi;
            out_none_next  = 1'b0;
            out_last_next  = (idx == '0);
            if (idx == '0) begin
              state_next = ST_IDLE;
            end else begin
              idx_next = idx - AW'(1);
              rd_addr  = idx - AW'(1);
            end
          end
        end else if (idx == '0) begin
          state_next = ST_NONE;
        end else begin
          idx_next = idx - AW'(1);
          rd_addr  = idx - AW'(1);
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_id_next    = '0;
          out_centi_next = '0;
          out_none_next  = 1'b1;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rmsq_chk.sv
module rmsq_chk
  import rmsq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("none-found transaction without last");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("none-found transaction carries data");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_LOAD) |=> s_tready)
    else $error("load transaction dropped ready");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_QUERY) |=> !s_tready)
    else $error("query transaction left ready high");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result transaction changed");

endmodule

bind record_merge_sort_threshold_query_unit rmsq_chk u_rmsq_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
